FILE: hdl/depq_pkg.sv
// Shared types and constants for the double-ended priority queue.
package depq_pkg;

  localparam int CAPACITY    = 64;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int VAL_W       = 32;
  localparam int MODE_W      = 2;
  localparam int OUT_USED_W  = 2 * VAL_W + 1 + CNT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT  = 2'd0,
    MODE_POP_MAX = 2'd1,
    MODE_POP_MIN = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT_DOWN
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e               cmd;
    logic signed [VAL_W-1:0] key;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

endpackage

FILE: hdl/depq_cell.sv
// One cell of the sorted chain: holds one entry, inserts or shifts toward cell 0.
module depq_cell (
  input  logic                             clk_i,
  input  depq_pkg::cell_ctl_t              ctl_i,
  input  logic                             valid_i,
  input  logic                             low_gt_i,
  input  logic signed [depq_pkg::VAL_W-1:0] low_value_i,
  input  logic signed [depq_pkg::VAL_W-1:0] up_value_i,
  output logic                             gt_o,
  output logic signed [depq_pkg::VAL_W-1:0] value_o
);
  import depq_pkg::*;

  logic signed [VAL_W-1:0] value_q, value_d;

  assign gt_o    = valid_i && (value_q > ctl_i.key);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    unique case (ctl_i.cmd)
      CMD_INSERT: begin
        // larger entries move up one cell; the key fills the gap or the first free cell
        if (low_gt_i) begin
          value_d = low_value_i;
        end else if (gt_o || !valid_i) begin
          value_d = ctl_i.key;
        end
      end
      CMD_SHIFT_DOWN: begin
        value_d = up_value_i;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

FILE: hdl/double_ended_priority_queue.sv
// Double-ended priority queue: a sorted chain of cells with a result register.
// Inputs are accepted only in ST_IDLE and update the cell chain and entry count.
// In ST_EVAL the max/min select and count go into the result register once it
// is free; no new input is accepted until that result has been loaded.
// Reset clears the entry count and the control state; cell contents are not reset.
module double_ended_priority_queue (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [depq_pkg::VAL_W-1:0]           s_axis_tdata,  // value
  input  logic [depq_pkg::MODE_W-1:0]          s_axis_tuser,  // mode
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // max_value, min_value, is_empty, entry_count, op_ignored, zero fill
  output logic [depq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import depq_pkg::*;

  logic                    accept;
  logic                    is_insert;
  logic                    is_pop_max;
  logic                    ignored;
  logic                    load_out;
  logic                    q_empty;
  cell_ctl_t               ctl;
  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    ignored_q;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]  out_data_q;
  logic signed [VAL_W-1:0] max_sel;
  logic signed [VAL_W-1:0] max_res, min_res;

  logic signed [VAL_W-1:0] cell_value [CAPACITY];
  logic                    cell_gt    [CAPACITY];
  logic                    cell_valid [CAPACITY];
  logic                    cell_top   [CAPACITY];

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign is_insert  = (s_axis_tuser == MODE_INSERT);
  assign is_pop_max = (s_axis_tuser == MODE_POP_MAX);
  assign q_empty    = (count_q == '0);
  assign ignored    = is_insert ? (count_q >= CNT_W'(CAPACITY)) : q_empty;

  always_comb begin
    ctl.key = s_axis_tdata;
    ctl.cmd = CMD_HOLD;
    if (accept && !ignored) begin
      priority if (is_insert) begin
        ctl.cmd = CMD_INSERT;
      end else if (is_pop_max) begin
        ctl.cmd = CMD_HOLD;
      end else begin
        ctl.cmd = CMD_SHIFT_DOWN;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (accept && !ignored) begin
      count_d = is_insert ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                    low_gt;
    logic signed [VAL_W-1:0] low_value;
    logic signed [VAL_W-1:0] up_value;

    assign cell_valid[g] = (count_q > CNT_W'(g));
    assign cell_top[g]   = (count_q == CNT_W'(g + 1));

    if (g == 0) begin : g_first
      assign low_gt    = 1'b0;
      assign low_value = cell_value[g];
    end else begin : g_inner
      assign low_gt    = cell_gt[g-1];
      assign low_value = cell_value[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign up_value = cell_value[g];
    end else begin : g_below
      assign up_value = cell_value[g+1];
    end

    depq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (cell_valid[g]),
      .low_gt_i    (low_gt),
      .low_value_i (low_value),
      .up_value_i  (up_value),
      .gt_o        (cell_gt[g]),
      .value_o     (cell_value[g])
    );
  end

  // one-hot select of the top entry
  always_comb begin
    max_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      max_sel = max_sel | (cell_top[i] ? cell_value[i] : '0);
    end
  end

  assign max_res = q_empty ? '0 : max_sel;
  assign min_res = q_empty ? '0 : cell_value[0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept)   state_d = ST_EVAL;
      ST_EVAL: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EVAL: load_out = !out_valid_q || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ignored_q <= ignored;
    end
    if (load_out) begin
      out_data_q <= {{OUT_PAD_W{1'b0}}, ignored_q, count_q, q_empty, min_res, max_res};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_insert && count_q < CNT_W'(CAPACITY))
      |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not add an entry");

  a_ends_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (cell_value[0] <= cell_value[1]))
    else $error("lowest cells out of order");

  a_empty_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && q_empty) |=> (m_axis_tdata[2*VAL_W-1:0] == '0
      && m_axis_tdata[2*VAL_W+CNT_W:2*VAL_W+1] == '0))
    else $error("empty result carries data");

endmodule
